>>> rtl/core/assert_macros.svh
// Assertion macros used by the checker file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

>>> rtl/core/e2q_pkg.sv
// Package for the Euler angle to quaternion core: widths, CORDIC constants.
// No dependencies.
package e2q_pkg;
  localparam int CordicSteps = 16;
  localparam int OutFracBits = 14;
  localparam int OutW = OutFracBits + 2;
  localparam int AngW = 16;
  localparam int Frac = 30;
  localparam int DW = 34;
  localparam int TableLen = 31;
  localparam int UsedSteps = (CordicSteps < TableLen) ? CordicSteps : TableLen;
  localparam int StepW = $clog2(UsedSteps);
  localparam logic signed [DW-1:0] GainQ = 34'sd652032874;
  localparam logic signed [DW-1:0] PiQ = 34'sd3373259426;
  localparam logic signed [DW-1:0] HalfPiQ = 34'sd1686629713;

  typedef logic signed [DW-1:0] dat_t;
  typedef logic signed [OutW-1:0] out_t;

  typedef struct packed {
    dat_t x;
    dat_t y;
    dat_t z;
    logic neg;
  } rot_t;

  typedef struct packed {
    rot_t yaw;
    rot_t pitch;
    rot_t roll;
  } rot3_t;

  function automatic dat_t atan_q(input int i);
    dat_t r;
    case (i)
      0: r = 34'sd843314857;
      1: r = 34'sd497837829;
      2: r = 34'sd263043837;
      3: r = 34'sd133525159;
      4: r = 34'sd67021687;
      5: r = 34'sd33543516;
      6: r = 34'sd16775851;
      7: r = 34'sd8388437;
      8: r = 34'sd4194283;
      9: r = 34'sd2097149;
      default: r = dat_t'(34'sd1 <<< (Frac - i));
    endcase
    return r;
  endfunction

  function automatic rot_t fold(input logic signed [AngW-1:0] a);
    rot_t r;
    dat_t z;
    z = dat_t'(a) <<< 16;
    r.x = GainQ;
    r.y = '0;
    r.neg = 1'b0;
    if (z > HalfPiQ) begin
      z = z - PiQ;
      r.neg = 1'b1;
    end else if (z < -HalfPiQ) begin
      z = z + PiQ;
      r.neg = 1'b1;
    end
    r.z = z;
    return r;
  endfunction

  function automatic rot_t rotate(input rot_t s, input int i);
    rot_t r;
    dat_t dx;
    dat_t dy;
    dx = s.y >>> i;
    dy = s.x >>> i;
    r = s;
    if (s.z >= 0) begin
      r.x = s.x - dx;
      r.y = s.y + dy;
      r.z = s.z - atan_q(i);
    end else begin
      r.x = s.x + dx;
      r.y = s.y - dy;
      r.z = s.z + atan_q(i);
    end
    return r;
  endfunction

  function automatic dat_t mul_q(input dat_t a, input dat_t b);
    logic signed [2*DW-1:0] p;
    p = (2*DW)'(a) * (2*DW)'(b) + (2*DW)'(64'sd1 <<< (Frac - 1));
    return DW'(p >>> Frac);
  endfunction

  function automatic out_t to_out(input dat_t v);
    logic signed [DW:0] r;
    logic signed [DW:0] lim;
    lim = (DW+1)'(1) <<< OutFracBits;
    r = ((DW+1)'(v) + ((DW+1)'(1) <<< (Frac - OutFracBits - 1))) >>> (Frac - OutFracBits);
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    return OutW'(r);
  endfunction
endpackage

>>> rtl/core/e2q_stream_if.sv
// Valid/ready stream interfaces, one for the input angles and one for the output quaternion.
// Depends on e2q_pkg.
interface e2q_in_if;
  logic valid;
  logic ready;
  logic signed [e2q_pkg::AngW-1:0] yaw_angle;
  logic signed [e2q_pkg::AngW-1:0] pitch_angle;
  logic signed [e2q_pkg::AngW-1:0] roll_angle;
  modport source (output valid, yaw_angle, pitch_angle, roll_angle, input ready);
  modport sink (input valid, yaw_angle, pitch_angle, roll_angle, output ready);
endinterface

interface e2q_out_if;
  logic valid;
  logic ready;
  e2q_pkg::out_t quat_x;
  e2q_pkg::out_t quat_y;
  e2q_pkg::out_t quat_z;
  e2q_pkg::out_t quat_w;
  modport source (output valid, quat_x, quat_y, quat_z, quat_w, input ready);
  modport sink (input valid, quat_x, quat_y, quat_z, quat_w, output ready);
endinterface

>>> rtl/core/e2q_cell.sv
// One CORDIC cell: rotates three angle lanes by the step given on step_i.
// Depends on e2q_pkg.
module e2q_cell (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic [e2q_pkg::StepW-1:0] step_i,
  input  e2q_pkg::rot3_t            rot_i,
  output e2q_pkg::rot3_t            rot_o
);
  e2q_pkg::rot3_t rot_q;
  e2q_pkg::rot3_t rot_d;

  always_comb begin
    rot_d.yaw   = e2q_pkg::rotate(rot_i.yaw, int'(step_i));
    rot_d.pitch = e2q_pkg::rotate(rot_i.pitch, int'(step_i));
    rot_d.roll  = e2q_pkg::rotate(rot_i.roll, int'(step_i));
  end

  always_ff @(posedge clk_i) begin
    if (en_i) rot_q <= rot_d;
  end

  assign rot_o = rot_q;
endmodule

>>> rtl/core/e2q_combine.sv
// Product stages: triple products, sums and output rounding.
// Depends on e2q_pkg.
module e2q_combine (
  input  logic           clk_i,
  input  logic [2:0]     en_i,
  input  e2q_pkg::rot3_t rot_i,
  output e2q_pkg::out_t  x_o,
  output e2q_pkg::out_t  y_o,
  output e2q_pkg::out_t  z_o,
  output e2q_pkg::out_t  w_o
);
  e2q_pkg::dat_t sy, cy, sp, cp, sr, cr;
  e2q_pkg::dat_t p_q [4];
  e2q_pkg::dat_t sr_q, cr_q;
  e2q_pkg::dat_t t_q [8];
  e2q_pkg::out_t o_q [4];

  always_comb begin
    sy = rot_i.yaw.neg ? -rot_i.yaw.y : rot_i.yaw.y;
    cy = rot_i.yaw.neg ? -rot_i.yaw.x : rot_i.yaw.x;
    sp = rot_i.pitch.neg ? -rot_i.pitch.y : rot_i.pitch.y;
    cp = rot_i.pitch.neg ? -rot_i.pitch.x : rot_i.pitch.x;
    sr = rot_i.roll.neg ? -rot_i.roll.y : rot_i.roll.y;
    cr = rot_i.roll.neg ? -rot_i.roll.x : rot_i.roll.x;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      p_q[0] <= e2q_pkg::mul_q(cy, sp);
      p_q[1] <= e2q_pkg::mul_q(sy, cp);
      p_q[2] <= e2q_pkg::mul_q(cy, cp);
      p_q[3] <= e2q_pkg::mul_q(sy, sp);
      sr_q <= sr;
      cr_q <= cr;
    end
    if (en_i[1]) begin
      t_q[0] <= e2q_pkg::mul_q(p_q[0], cr_q);
      t_q[1] <= e2q_pkg::mul_q(p_q[1], sr_q);
      t_q[2] <= e2q_pkg::mul_q(p_q[1], cr_q);
      t_q[3] <= e2q_pkg::mul_q(p_q[0], sr_q);
      t_q[4] <= e2q_pkg::mul_q(p_q[2], sr_q);
      t_q[5] <= e2q_pkg::mul_q(p_q[3], cr_q);
      t_q[6] <= e2q_pkg::mul_q(p_q[2], cr_q);
      t_q[7] <= e2q_pkg::mul_q(p_q[3], sr_q);
    end
    if (en_i[2]) begin
      o_q[0] <= e2q_pkg::to_out(t_q[0] + t_q[1]);
      o_q[1] <= e2q_pkg::to_out(t_q[2] - t_q[3]);
      o_q[2] <= e2q_pkg::to_out(t_q[4] - t_q[5]);
      o_q[3] <= e2q_pkg::to_out(t_q[6] + t_q[7]);
    end
  end

  assign x_o = o_q[0];
  assign y_o = o_q[1];
  assign z_o = o_q[2];
  assign w_o = o_q[3];
endmodule

>>> rtl/core/euler_to_quaternion_top.sv
// Euler yaw/pitch/roll to unit quaternion, CORDIC cell chain plus product stages.
// Depends on e2q_pkg, e2q_stream_if, e2q_cell, e2q_combine.
//
//   channel  dir  payload
//   in_if    in   yaw_angle, pitch_angle, roll_angle (Q1.14)
//   out_if   out  quat_x, quat_y, quat_z, quat_w (Q1.14)
//
// One beat per cycle while the output is not stalled; the stages are fold, one cell
// per CORDIC step, two product stages and a rounding stage.
// The pipeline advances whenever the output stage is empty or being taken.
// Reset clears the valid bits only.
module euler_to_quaternion_top (
  input logic   clk_i,
  input logic   rst_ni,
  e2q_in_if.sink    in_if,
  e2q_out_if.source out_if
);
  localparam int Stages = e2q_pkg::UsedSteps + 4;

  logic [Stages-1:0] vld_q;
  logic [Stages-1:0] vld_d;
  logic adv;
  e2q_pkg::rot3_t chain [e2q_pkg::UsedSteps+1];
  e2q_pkg::rot3_t fold_q;

  assign adv = !vld_q[Stages-1] || out_if.ready;
  assign in_if.ready = adv;

  always_comb begin
    vld_d = {vld_q[Stages-2:0], in_if.valid};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      fold_q.yaw   <= e2q_pkg::fold(in_if.yaw_angle);
      fold_q.pitch <= e2q_pkg::fold(in_if.pitch_angle);
      fold_q.roll  <= e2q_pkg::fold(in_if.roll_angle);
    end
  end

  assign chain[0] = fold_q;

  for (genvar g = 0; g < e2q_pkg::UsedSteps; g++) begin : g_cell
    e2q_cell u_cell (
      .clk_i  (clk_i),
      .en_i   (adv),
      .step_i (e2q_pkg::StepW'(g)),
      .rot_i  (chain[g]),
      .rot_o  (chain[g+1])
    );
  end

  e2q_combine u_combine (
    .clk_i (clk_i),
    .en_i  ({3{adv}}),
    .rot_i (chain[e2q_pkg::UsedSteps]),
    .x_o   (out_if.quat_x),
    .y_o   (out_if.quat_y),
    .z_o   (out_if.quat_z),
    .w_o   (out_if.quat_w)
  );

  assign out_if.valid = vld_q[Stages-1];
endmodule

>>> rtl/core/e2q_checker.sv
// Port-level checker for the quaternion core, bound to the top level.
// Depends on assert_macros.svh, e2q_pkg.
`include "assert_macros.svh"
module e2q_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_ready_i,
  input logic          out_valid_i,
  input logic          out_ready_i,
  input e2q_pkg::out_t quat_x_i,
  input e2q_pkg::out_t quat_w_i
);
  localparam e2q_pkg::out_t One = e2q_pkg::out_t'(1) <<< e2q_pkg::OutFracBits;

  `ASSERT_NEXT(a_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(quat_x_i))
  `ASSERT_IMPL(a_rdy, clk_i, rst_ni, !out_valid_i, in_ready_i)
  `ASSERT_IMPL(a_wrng, clk_i, rst_ni, out_valid_i, quat_w_i <= One && quat_w_i >= -One)
  `ASSERT_IMPL(a_xrng, clk_i, rst_ni, out_valid_i, quat_x_i <= One && quat_x_i >= -One)
endmodule

bind euler_to_quaternion_top e2q_checker u_e2q_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (in_if.ready),
  .out_valid_i (out_if.valid),
  .out_ready_i (out_if.ready),
  .quat_x_i    (out_if.quat_x),
  .quat_w_i    (out_if.quat_w)
);
